// ===== design/strict_utf8_validator_macros.svh =====
// Assertion macros used by the strict UTF-8 validator RTL.
`ifndef STRICT_UTF8_VALIDATOR_MACROS_SVH
`define STRICT_UTF8_VALIDATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SU8V_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SU8V_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/su8val_pkg.sv =====
// Constants and types for the strict UTF-8 validator.
package su8val_pkg;

  localparam int PendingW = 2;
  localparam int PointW   = 21;
  localparam int WidthW   = 3;

  // Lead byte ranges.
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;

  // Continuation byte form.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  // Code point limits.
  localparam logic [PointW-1:0] MIN_3BYTE = 21'h000800;
  localparam logic [PointW-1:0] MIN_4BYTE = 21'h010000;
  localparam logic [PointW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [PointW-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [PointW-1:0] MAX_POINT = 21'h10FFFF;

  // Sequence widths.
  localparam logic [WidthW-1:0] SEQ_NONE = 3'd0;
  localparam logic [WidthW-1:0] SEQ_1    = 3'd1;
  localparam logic [WidthW-1:0] SEQ_2    = 3'd2;
  localparam logic [WidthW-1:0] SEQ_3    = 3'd3;
  localparam logic [WidthW-1:0] SEQ_4    = 3'd4;

  typedef struct packed {
    logic [PendingW-1:0] bytes_pending;
    logic [PointW-1:0]   partial_point;
    logic [WidthW-1:0]   seq_width;
    logic                error_seen;
  } dec_state_t;

  localparam dec_state_t DEC_CLEAR = '{
    bytes_pending: '0,
    partial_point: '0,
    seq_width:     SEQ_NONE,
    error_seen:    1'b0
  };

endpackage

// ===== design/strict_utf8_validator.sv =====
// Strict UTF-8 string validator: byte-wise decoder with a registered verdict.
// Latency: the verdict for a string appears in the cycle after its final byte transfers.
// Throughput: one byte per cycle; the decoder state updates in the accepting cycle.
// A byte stalls only while a verdict is held in the output register and out_ready is low.
// Reset (rst, synchronous, active high) clears the decoder state and the output valid.
`include "strict_utf8_validator_macros.svh"

module strict_utf8_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       text_valid
);
  import su8val_pkg::*;

  // Decoder state held between bytes of one string.
  dec_state_t dec;
  dec_state_t dec_next;

  // State after the current byte, before the end-of-string clear.
  dec_state_t stepped;

  logic                in_xfer;
  logic                verdict;
  logic [PointW-1:0]   shifted_point;
  logic [PendingW-1:0] pending_dec;

  // The input side stalls only when a verdict is held and not being taken.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Continuation bytes append six payload bits to the code point.
  assign shifted_point = {dec.partial_point[PointW-7:0], text_byte[5:0]};
  assign pending_dec   = dec.bytes_pending - 2'd1;

  // Decode one byte. Once an error has been seen the rest of the string is
  // ignored, and the error path always leaves the decoder fields cleared.
  always_comb begin
    stepped = dec;
    if (!dec.error_seen) begin
      if (dec.bytes_pending == '0) begin
        // A lead byte is expected.
        if (text_byte == '0) begin
          stepped = DEC_CLEAR;
          stepped.error_seen = 1'b1;
        end else if (text_byte <= ASCII_MAX) begin
          stepped.seq_width     = SEQ_1;
          stepped.partial_point = PointW'(text_byte);
          stepped.bytes_pending = 2'd0;
        end else if (text_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
          stepped.seq_width     = SEQ_2;
          stepped.partial_point = PointW'(text_byte[4:0]);
          stepped.bytes_pending = 2'd1;
        end else if (text_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
          stepped.seq_width     = SEQ_3;
          stepped.partial_point = PointW'(text_byte[3:0]);
          stepped.bytes_pending = 2'd2;
        end else if (text_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
          stepped.seq_width     = SEQ_4;
          stepped.partial_point = PointW'(text_byte[2:0]);
          stepped.bytes_pending = 2'd3;
        end else begin
          // Stray continuation, C0, C1 or F5 and above.
          stepped = DEC_CLEAR;
          stepped.error_seen = 1'b1;
        end
      end else begin
        // A continuation byte is expected.
        if ((text_byte & CONT_MASK) != CONT_TAG) begin
          stepped = DEC_CLEAR;
          stepped.error_seen = 1'b1;
        end else begin
          stepped.partial_point = shifted_point;
          stepped.bytes_pending = pending_dec;
          // When the sequence completes, reject overlong forms, surrogates
          // and anything beyond the last code point.
          if (pending_dec == '0) begin
            if ((dec.seq_width == SEQ_3 && shifted_point < MIN_3BYTE) ||
                (dec.seq_width == SEQ_4 && shifted_point < MIN_4BYTE) ||
                (shifted_point >= SURR_LO && shifted_point <= SURR_HI) ||
                (shifted_point > MAX_POINT)) begin
              stepped = DEC_CLEAR;
              stepped.error_seen = 1'b1;
            end
          end
        end
      end
    end
  end

  // A string is valid when no error was seen and no sequence is left open.
  assign verdict = !stepped.error_seen && (stepped.bytes_pending == '0);

  // The final byte returns the decoder to its reset state.
  always_comb begin
    dec_next = dec;
    if (in_xfer) begin
      dec_next = final_byte ? DEC_CLEAR : stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= DEC_CLEAR;
    end else begin
      dec <= dec_next;
    end
  end

  // Result register: loaded on the final byte, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && final_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && final_byte) begin
      text_valid <= verdict;
    end
  end

  // After an error only the sticky flag remains; the decoder fields are clear.
  `SU8V_ASSERT_SAME(a_err_clears_decoder, clk, rst, dec.error_seen,
    dec.bytes_pending == '0 && dec.partial_point == '0 && dec.seq_width == SEQ_NONE,
    "decoder fields not cleared after an error")
  // The number of pending continuation bytes is below the sequence width.
  `SU8V_ASSERT_SAME(a_pending_fits_width, clk, rst, dec.bytes_pending != '0,
    dec.seq_width > WidthW'(dec.bytes_pending),
    "pending continuation count exceeds the sequence width")
  // A final byte transfer leaves the decoder in its reset state.
  `SU8V_ASSERT_NEXT(a_final_clears_state, clk, rst, in_xfer && final_byte,
    dec == DEC_CLEAR, "decoder state not cleared after the final byte")
  // A final byte transfer always yields a held verdict in the next cycle.
  `SU8V_ASSERT_NEXT(a_final_gives_result, clk, rst, in_xfer && final_byte,
    out_valid, "no verdict after the final byte")

endmodule
